// File: rtl/tlru_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlru_pkg
// Shared types, defaults and elaboration helpers for the two-way LRU tag model.
// ----------------------------------------------------------------------------
package tlru_pkg;

	localparam int CACHE_BYTES_DEF = 4096;
	localparam int LINE_BYTES_DEF  = 16;
	localparam int ADDR_BITS_DEF   = 32;
	localparam int WAYS            = 2;
	localparam int WORD_W          = 32;

	typedef struct packed {
		logic [WORD_W-1:0] address;
	} in_word_t;

	typedef struct packed {
		logic              hit;
		logic              way_used;
		logic [WORD_W-1:0] access_total;
		logic [WORD_W-1:0] miss_total;
	} out_word_t;

	// floor(log2(v)), zero for v <= 1; used on constants only
	function automatic int floor_log2(input longint v);
		int n;
		n = 0;
		for (int i = 1; i < 63; i++) begin
			if ((v >> i) != 0) begin
				n = i;
			end
		end
		return n;
	endfunction

endpackage

// File: rtl/tlru_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlru_stream_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface tlru_stream_if #(
	parameter type word_t = logic
) ();
	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/tlru_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlru_ram
// Simple dual-port set memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tlru_ram #(
	parameter int DATA_W = 45,
	parameter int ADDR_W = 7,
	parameter int DEPTH  = 128
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// read returns the old contents on a same-address write
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	assign rdata = rd_q;

endmodule

// File: rtl/two_way_lru_cache_tag_model_top.sv
`timescale 1ns / 1ps
// Path: an accepted word goes through the read stage, then the output register, to result.
// Throughput: one lookup per cycle unless result stalls, set by the single read/write port
//   pair of the set RAM; a lookup to the set written just before takes the forwarded row.
// Reset: arst_n clears counters and control; afterwards a clearing pass writes every set
//   row once (2**set bits rows, 128 with the defaults) while lookup.ready stays low.
// ----------------------------------------------------------------------------
// two_way_lru_cache_tag_model_top
// Hit/miss model of a two-way set-associative cache with one LRU bit per set.
// ----------------------------------------------------------------------------
module two_way_lru_cache_tag_model_top #(
	parameter int CACHE_BYTES = tlru_pkg::CACHE_BYTES_DEF,
	parameter int LINE_BYTES  = tlru_pkg::LINE_BYTES_DEF,
	parameter int ADDR_BITS   = tlru_pkg::ADDR_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	tlru_stream_if.sink          lookup,
	tlru_stream_if.source        result
);

	// ---- address split, all worked out at elaboration ----
	localparam int OFF_W    = tlru_pkg::floor_log2(LINE_BYTES);
	localparam int NUM_SETS = CACHE_BYTES / LINE_BYTES / tlru_pkg::WAYS;
	localparam int SLOTS    = (NUM_SETS > 0) ? NUM_SETS : 1;
	localparam int SET_W    = tlru_pkg::floor_log2(SLOTS);
	localparam int EFF_A    = (ADDR_BITS < tlru_pkg::WORD_W) ? ADDR_BITS : tlru_pkg::WORD_W;
	localparam int TAG_SH   = OFF_W + SET_W;
	localparam int TAG_W    = (EFF_A > TAG_SH) ? EFF_A - TAG_SH : 1;
	localparam int IDX_W    = (SET_W > 0) ? SET_W : 1;
	localparam int DEPTH    = 1 << SET_W;
	localparam logic [tlru_pkg::WORD_W-1:0] ADDR_MASK =
		(EFF_A >= tlru_pkg::WORD_W) ? '1 : ((tlru_pkg::WORD_W'(1) << EFF_A) - 1'b1);

	// one RAM row holds the whole set: both valid bits, the LRU bit and both tags
	typedef struct packed {
		logic             v0;
		logic             v1;
		logic             r0;   // way 0 used most recently
		logic [TAG_W-1:0] t0;
		logic [TAG_W-1:0] t1;
	} row_t;

	localparam int ROW_W = $bits(row_t);

	// ---- input side ----
	logic [tlru_pkg::WORD_W-1:0] addr_m;
	logic [IDX_W-1:0]            in_idx;
	logic [TAG_W-1:0]            in_tag;
	logic                        adv;
	logic                        accept;

	// ---- read stage ----
	logic             v_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [TAG_W-1:0] tag_s1;

	// ---- clearing pass ----
	logic             clr_q;
	logic [IDX_W-1:0] clr_cnt_q;

	// ---- forwarding ----
	logic byp_q;
	row_t wrow_q;

	// ---- RAM ports ----
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	row_t             ram_wdata;
	logic [ROW_W-1:0] ram_rdata;

	// ---- update logic ----
	row_t cur_row;
	row_t new_row;
	logic hit0;
	logic hit1;
	logic hit;
	logic fill0;
	logic way;
	logic proc;

	// ---- counters and output register ----
	logic [tlru_pkg::WORD_W-1:0] acc_q;
	logic [tlru_pkg::WORD_W-1:0] miss_q;
	logic [tlru_pkg::WORD_W-1:0] acc_next;
	logic [tlru_pkg::WORD_W-1:0] miss_next;
	logic                        out_valid_q;
	tlru_pkg::out_word_t         out_q;

	// Drop address bits above ADDR_BITS, then cut out set index and tag.
	assign addr_m = lookup.data.address & ADDR_MASK;
	assign in_idx = (SET_W > 0) ? IDX_W'(addr_m >> OFF_W) : '0;
	assign in_tag = TAG_W'(addr_m >> TAG_SH);

	// The whole pipe moves when the output register is empty or being drained.
	// The read-stage word is always finished in a cycle where adv is high.
	assign adv          = !out_valid_q || result.ready;
	assign lookup.ready = adv && !clr_q;
	assign accept       = lookup.valid && lookup.ready;
	assign proc         = v_s1 && adv;

	// Row seen by the read-stage word: forwarded when the word ahead wrote the same set.
	assign cur_row = byp_q ? wrow_q : row_t'(ram_rdata);

	assign hit0  = cur_row.v0 && (cur_row.t0 == tag_s1);
	assign hit1  = cur_row.v1 && (cur_row.t1 == tag_s1);
	assign hit   = hit0 || hit1;
	// Fill way 0 when it is empty, or when way 1 is full and way 0 is the older one.
	assign fill0 = !cur_row.v0 || (!cur_row.r0 && cur_row.v1);

	always_comb begin
		new_row = cur_row;
		way     = 1'b0;
		priority if (hit) begin
			// way 0 wins if both match
			way        = !hit0;
			new_row.r0 = hit0;
		end else if (fill0) begin
			way        = 1'b0;
			new_row.t0 = tag_s1;
			new_row.v0 = 1'b1;
			new_row.r0 = 1'b1;
		end else begin
			way        = 1'b1;
			new_row.t1 = tag_s1;
			new_row.v1 = 1'b1;
			new_row.r0 = 1'b0;
		end
	end

	assign acc_next  = acc_q + 1'b1;
	assign miss_next = miss_q + tlru_pkg::WORD_W'(!hit);

	// Write back on every finished word; during the clearing pass write empty rows.
	assign ram_we    = clr_q || proc;
	assign ram_waddr = clr_q ? clr_cnt_q : idx_s1;
	assign ram_wdata = clr_q ? row_t'('0) : new_row;

	tlru_ram #(
		.DATA_W (ROW_W),
		.ADDR_W (IDX_W),
		.DEPTH  (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (in_idx),
		.rdata (ram_rdata)
	);

	// Clearing pass: one row per cycle after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == IDX_W'(DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// Read stage control and forwarding flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			byp_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept;
			// the RAM returns the stale row when it is written at the read edge
			byp_q <= accept && proc && (in_idx == idx_s1);
		end
	end

	// Read stage payload; the forwarded row holds while the pipe stalls.
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1 <= in_idx;
			tag_s1 <= in_tag;
		end
		if (proc) begin
			wrow_q <= new_row;
		end
	end

	// Counters and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			miss_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= proc;
			if (proc) begin
				acc_q  <= acc_next;
				miss_q <= miss_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			out_q.hit          <= hit;
			out_q.way_used     <= way;
			out_q.access_total <= acc_next;
			out_q.miss_total   <= miss_next;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_q;

`ifndef NO_ASSERTIONS
	// No lookup is taken while the clearing pass runs.
	a_no_accept_in_clear : assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !lookup.ready)
		else $error("lookup accepted during clearing pass");

	// A finished word always lands in the output register.
	a_proc_to_result : assert property (@(posedge clk) disable iff (!arst_n)
		proc |=> result.valid)
		else $error("finished word did not reach the result register");

	// The access counter advances by one per finished word and holds otherwise.
	a_acc_step : assert property (@(posedge clk) disable iff (!arst_n)
		proc |=> (acc_q == $past(acc_q) + 1'b1))
		else $error("access counter did not advance");

	a_acc_hold : assert property (@(posedge clk) disable iff (!arst_n)
		!proc |=> $stable(acc_q))
		else $error("access counter moved without a word");

	// Forwarding is only armed for a word sitting in the read stage.
	a_byp_needs_s1 : assert property (@(posedge clk) disable iff (!arst_n)
		byp_q |-> v_s1)
		else $error("forward flag set with empty read stage");
`endif

endmodule

// File: test/two_way_lru_cache_tag_model_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_way_lru_cache_tag_model_top_tb
// Drives byte addresses into the two-way LRU tag model and checks every result
// word (hit, way, access and miss totals) against a cycle-free lookup predictor.
// The stimulus opens with a directed run through fills, hits and LRU evictions,
// then random traffic aimed at a few hot sets. Both channels idle at random.
// ----------------------------------------------------------------------------
module two_way_lru_cache_tag_model_top_tb;

	import tlru_pkg::*;

	// Address split for the default geometry
	localparam int OFF_W     = $clog2(LINE_BYTES_DEF);
	localparam int SET_W     = $clog2(CACHE_BYTES_DEF / LINE_BYTES_DEF / WAYS);
	localparam int TAG_W     = WORD_W - OFF_W - SET_W;
	localparam int SET_N     = 1 << SET_W;
	localparam int RAND_N    = 550;
	localparam int MAX_GAP   = 10;
	localparam int SHOW_MAX  = 20;

	logic clk;
	logic arst_n;

	tlru_stream_if #(.word_t(in_word_t))  lookup_if ();
	tlru_stream_if #(.word_t(out_word_t)) result_if ();

	two_way_lru_cache_tag_model_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.lookup (lookup_if.sink),
		.result (result_if.source)
	);

	// Predictor state: two tags, two valid bits and one way-0-recent bit per set
	logic [TAG_W-1:0]  tag_way0 [SET_N];
	logic [TAG_W-1:0]  tag_way1 [SET_N];
	bit                live_way0 [SET_N];
	bit                live_way1 [SET_N];
	bit                mru_way0 [SET_N];
	logic [WORD_W-1:0] acc_cnt;
	logic [WORD_W-1:0] miss_cnt;

	in_word_t  pending_q [$];
	out_word_t lookup_expect_q [$];

	int lookup_gap;
	int result_stall;
	int sent_n;
	int got_n;
	int hits_seen;
	int errors;

	// Look up one address in the predicted cache and advance its state.
	function automatic out_word_t lookup_predict(input logic [WORD_W-1:0] addr);
		logic [SET_W-1:0] set_i;
		logic [TAG_W-1:0] tag_i;
		bit               hit0;
		bit               hit1;
		out_word_t        res;
		set_i = addr[OFF_W +: SET_W];
		tag_i = addr[WORD_W-1 -: TAG_W];
		acc_cnt = acc_cnt + 1;
		// a way only matches while it holds a valid line
		hit0 = live_way0[set_i] && (tag_way0[set_i] == tag_i);
		hit1 = live_way1[set_i] && (tag_way1[set_i] == tag_i);
		res.hit = hit0 || hit1;
		if (hit0 || hit1) begin
			res.way_used = !hit0;
			mru_way0[set_i] = hit0;
		end else if (!live_way0[set_i] || (!mru_way0[set_i] && live_way1[set_i])) begin
			// way 0 is empty, or both are full and way 1 was touched last
			tag_way0[set_i]  = tag_i;
			live_way0[set_i] = 1'b1;
			mru_way0[set_i]  = 1'b1;
			res.way_used     = 1'b0;
		end else begin
			tag_way1[set_i]  = tag_i;
			live_way1[set_i] = 1'b1;
			mru_way0[set_i]  = 1'b0;
			res.way_used     = 1'b1;
		end
		if (!res.hit) begin
			miss_cnt = miss_cnt + 1;
		end
		res.access_total = acc_cnt;
		res.miss_total   = miss_cnt;
		return res;
	endfunction

	function automatic logic [WORD_W-1:0] addr_of(input logic [TAG_W-1:0] t,
			input logic [SET_W-1:0] s, input logic [OFF_W-1:0] o);
		return {t, s, o};
	endfunction

	// Print one line for the first few mismatches, count all of them.
	task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
			input logic [WORD_W-1:0] want);
		errors++;
		if (errors <= SHOW_MAX) begin
			$display("[%0t] result word %0d: %s got 0x%08h want 0x%08h",
				$realtime, got_n, what, got, want);
		end
	endtask

	task automatic check_result(input out_word_t got);
		out_word_t want;
		if (lookup_expect_q.size() == 0) begin
			report_mismatch("unexpected word", got.access_total, '0);
		end else begin
			want = lookup_expect_q.pop_front();
			if (got.hit !== want.hit)
				report_mismatch("hit", WORD_W'(got.hit), WORD_W'(want.hit));
			if (got.way_used !== want.way_used)
				report_mismatch("way_used", WORD_W'(got.way_used), WORD_W'(want.way_used));
			if (got.access_total !== want.access_total)
				report_mismatch("access_total", got.access_total, want.access_total);
			if (got.miss_total !== want.miss_total)
				report_mismatch("miss_total", got.miss_total, want.miss_total);
		end
		if (got.hit === 1'b1) begin
			hits_seen++;
		end
	endtask

	// Clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Driver: present the pending words in order, idle a drawn number of cycles
	// after each accepted word. Every 150 words, 50 go out back to back.
	always @(posedge clk or negedge arst_n) begin : lookup_driver
		int gap_now;
		if (!arst_n) begin
			lookup_if.valid <= 1'b0;
			lookup_if.data  <= '0;
			lookup_gap      <= 0;
		end else if (!lookup_if.valid || lookup_if.ready) begin
			if (lookup_if.valid) begin
				// word accepted at this edge: predict its result now
				lookup_expect_q.push_back(lookup_predict(lookup_if.data.address));
				sent_n++;
				gap_now = ((sent_n % 150) >= 100) ? 0 : $urandom_range(0, MAX_GAP);
			end else begin
				gap_now = lookup_gap;
			end
			if (gap_now > 0 || pending_q.size() == 0) begin
				lookup_if.valid <= 1'b0;
				lookup_gap      <= (gap_now > 0) ? gap_now - 1 : 0;
			end else begin
				lookup_if.valid <= 1'b1;
				lookup_if.data  <= pending_q.pop_front();
				lookup_gap      <= 0;
			end
		end
	end

	// Monitor: check each accepted result word, then drop ready for a drawn
	// number of cycles. Every 130 words, 40 are taken without a stall.
	always @(posedge clk or negedge arst_n) begin : result_monitor
		int stall;
		if (!arst_n) begin
			result_if.ready <= 1'b0;
			result_stall    <= 0;
		end else if (result_if.valid && result_if.ready) begin
			check_result(result_if.data);
			got_n++;
			stall = ((got_n % 130) >= 90) ? 0 : $urandom_range(0, MAX_GAP);
			result_if.ready <= (stall == 0);
			result_stall    <= stall;
		end else if (result_stall > 0) begin
			result_stall    <= result_stall - 1;
			result_if.ready <= (result_stall == 1);
		end else begin
			result_if.ready <= 1'b1;
		end
	end

	// Stimulus, reset and end of run
	initial begin : stimulus
		logic [TAG_W-1:0]  hot_tag [4][3];
		logic [SET_W-1:0]  hot_set [4];
		logic [WORD_W-1:0] prev;
		logic [WORD_W-1:0] a;
		in_word_t          w;
		int                r;
		int                si;

		lookup_if.valid = 1'b0;
		lookup_if.data  = '0;
		result_if.ready = 1'b0;
		arst_n          = 1'b0;
		acc_cnt         = '0;
		miss_cnt        = '0;
		for (int i = 0; i < SET_N; i++) begin
			tag_way0[i]  = '0;
			tag_way1[i]  = '0;
			live_way0[i] = 1'b0;
			live_way1[i] = 1'b0;
			mru_way0[i]  = 1'b0;
		end

		// Directed: address extremes, same-line hits, then one set walked through
		// both fills and alternating LRU evictions.
		pending_q.push_back(in_word_t'(32'h0000_0000));
		pending_q.push_back(in_word_t'(32'h0000_000F));
		pending_q.push_back(in_word_t'(32'hFFFF_FFFF));
		pending_q.push_back(in_word_t'(32'hFFFF_FFF0));
		pending_q.push_back(in_word_t'(addr_of(1, 0, 3)));   // way 1 still empty
		pending_q.push_back(in_word_t'(addr_of(0, 0, 7)));   // hit way 0
		pending_q.push_back(in_word_t'(addr_of(2, 0, 0)));   // evict way 1
		pending_q.push_back(in_word_t'(addr_of(1, 0, 0)));   // evict way 0
		pending_q.push_back(in_word_t'(addr_of(2, 0, 9)));   // hit way 1
		pending_q.push_back(in_word_t'(addr_of(1, 0, 2)));   // hit way 0
		pending_q.push_back(in_word_t'(addr_of(0, 0, 1)));   // evict way 1
		pending_q.push_back(in_word_t'(addr_of(0, 0, 1)));
		pending_q.push_back(in_word_t'(32'hAAAA_AAAA));
		pending_q.push_back(in_word_t'(32'h5555_5555));
		pending_q.push_back(in_word_t'(32'hAAAA_AAA5));
		pending_q.push_back(in_word_t'(addr_of('1, 7'd127, 0))); // hit way 0 of top set
		pending_q.push_back(in_word_t'(addr_of(0, 7'd127, 0)));  // fills way 1
		pending_q.push_back(in_word_t'(addr_of('1, 7'd127, 5)));
		pending_q.push_back(in_word_t'(addr_of(3, 5, 0)));
		pending_q.push_back(in_word_t'(addr_of(4, 5, 0)));
		pending_q.push_back(in_word_t'(addr_of(3, 5, 15)));
		pending_q.push_back(in_word_t'(addr_of(5, 5, 0)));

		// Random: mostly a few hot sets with three tags each, so the two ways
		// keep thrashing; some repeats of the last line or set, some raw noise.
		hot_set[0] = '0;
		hot_set[1] = '1;
		hot_set[2] = SET_W'($urandom);
		hot_set[3] = SET_W'($urandom);
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 3; j++) begin
				hot_tag[i][j] = TAG_W'($urandom);
			end
		end
		prev = 32'hFFFF_FFFF;
		for (int n = 0; n < RAND_N; n++) begin
			r = $urandom_range(0, 99);
			if (r < 60) begin
				si = $urandom_range(0, 3);
				a  = addr_of(hot_tag[si][$urandom_range(0, 2)], hot_set[si],
					OFF_W'($urandom));
			end else if (r < 72) begin
				a = {prev[WORD_W-1:OFF_W], OFF_W'($urandom)};
			end else if (r < 80) begin
				a = addr_of(TAG_W'($urandom), prev[OFF_W +: SET_W], OFF_W'($urandom));
			end else begin
				a = $urandom;
			end
			w.address = a;
			pending_q.push_back(w);
			prev = a;
		end

		// Hold reset, then release it away from the rising edge
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for every word to go in, every result to come out, then drain
		while (pending_q.size() != 0 || lookup_if.valid) @(posedge clk);
		while (lookup_expect_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Checked %0d lookups (%0d hits, %0d misses) over directed and hot-set random",
			got_n, hits_seen, got_n - hits_seen);
		$display("traffic, with random idle and stall cycles on both channels; %0d mismatches.",
			errors);
		if (errors == 0 && lookup_expect_q.size() == 0 && got_n == sent_n) begin
			$display("two_way_lru_cache_tag_model_top_tb passed");
		end else begin
			$display("two_way_lru_cache_tag_model_top_tb failed");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run including the clearing pass
	initial begin : watchdog
		#2_000_000;
		$display("Timed out with %0d words sent and %0d results checked.", sent_n, got_n);
		$display("two_way_lru_cache_tag_model_top_tb failed");
		$finish;
	end

endmodule
